// ===== rtl/svpf_pkg.sv =====
`default_nettype none
package svpf_pkg;

  // largest entry counts a sync packet may announce
  localparam int MAX_SYNC_WRITE_ENTRIES = 6;
  localparam int MAX_SYNC_READ_ENTRIES  = 24;

  // command codes as they arrive on the mode field
  typedef enum logic [1:0] {
    OP_TORQUE     = 2'd0,
    OP_WRITE_POS  = 2'd1,
    OP_SYNC_WRITE = 2'd2,
    OP_SYNC_READ  = 2'd3
  } op_t;

  // packet constants
  localparam logic [7:0] HDR_BYTE       = 8'hFF;
  localparam logic [7:0] BCAST_ID       = 8'hFE;
  localparam logic [7:0] INS_WRITE      = 8'h03;
  localparam logic [7:0] INS_SYNC_WRITE = 8'h83;
  localparam logic [7:0] INS_SYNC_READ  = 8'h82;
  localparam logic [7:0] ADDR_TORQUE    = 8'h28;
  localparam logic [7:0] ADDR_GOAL      = 8'h29;
  localparam logic [7:0] ADDR_PRESENT   = 8'h38;
  localparam logic [7:0] LEN_TORQUE     = 8'h05;
  localparam logic [7:0] LEN_WRITE_POS  = 8'h0A;
  localparam logic [7:0] SW_DATA_LEN    = 8'h07;
  localparam logic [7:0] SR_DATA_LEN    = 8'h06;
  localparam logic [7:0] SYNC_LEN_BASE  = 8'h04;

  // byte position where a sync entry starts when no header goes first
  localparam logic [3:0] SYNC_ENTRY_POS = 4'd7;

  // one classified command handed from front to back
  typedef struct packed {
    op_t         op;
    logic        hdr;       // emit sync header before the entry
    logic        chk;       // close the packet with the checksum
    logic [7:0]  len;       // length byte of a sync header
    logic [7:0]  servo_id;
    logic        enable;
    logic [7:0]  acceleration;
    logic [15:0] position;
    logic [15:0] move_time;
    logic [15:0] move_speed;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/svpf_front.sv =====
`default_nettype none
module svpf_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         servo_id,
  input  wire logic               enable,
  input  wire logic [7:0]         acceleration,
  input  wire logic [15:0]        position,
  input  wire logic [15:0]        move_time,
  input  wire logic [15:0]        move_speed,
  input  wire logic [4:0]         entry_count,
  output logic                    job_push,
  output svpf_pkg::job_t          job
);
  import svpf_pkg::*;

  logic [4:0] entries_left;
  logic [4:0] entries_left_next;
  logic       open_kind;
  logic       open_kind_next;

  logic       kind;
  logic       pkt_open;
  logic       bad_count;
  logic [4:0] left_now;

  // classify the command against the open sync packet
  always_comb begin
    kind      = mode[0];
    pkt_open  = (entries_left != 5'd0) && (open_kind == kind);
    bad_count = (entry_count == 5'd0) ||
                (kind ? (int'(entry_count) > MAX_SYNC_READ_ENTRIES)
                      : (int'(entry_count) > MAX_SYNC_WRITE_ENTRIES));
    left_now  = pkt_open ? entries_left : entry_count;

    job.op           = op_t'(mode);
    job.servo_id     = servo_id;
    job.enable       = enable;
    job.acceleration = acceleration;
    job.position     = position;
    job.move_time    = move_time;
    job.move_speed   = move_speed;
    job.len          = kind ? ({3'b000, entry_count} + SYNC_LEN_BASE)
                            : ({entry_count, 3'b000} + SYNC_LEN_BASE);
    job.hdr          = 1'b1;
    job.chk          = 1'b1;
    job_push         = 1'b0;
    entries_left_next = entries_left;
    open_kind_next    = open_kind;

    if (take) begin
      if (!mode[1]) begin
        // whole packet, any open sync packet is abandoned
        entries_left_next = 5'd0;
        job_push          = 1'b1;
      end else if (!pkt_open && bad_count) begin
        // dropped, nothing emitted
        entries_left_next = 5'd0;
      end else begin
        job_push          = 1'b1;
        job.hdr           = !pkt_open;
        entries_left_next = left_now - 5'd1;
        job.chk           = (left_now == 5'd1);
        open_kind_next    = kind;
      end
    end
  end

  // sync packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_left <= 5'd0;
      open_kind    <= 1'b0;
    end else begin
      entries_left <= entries_left_next;
      open_kind    <= open_kind_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/svpf_queue.sv =====
`default_nettype none
module svpf_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire svpf_pkg::job_t     push_job,
  output logic                    full,
  input  wire logic               pop,
  output logic                    job_valid,
  output svpf_pkg::job_t          head_job
);
  import svpf_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  job_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == (PW+1)'(DEPTH));
  assign job_valid = (count != '0);
  assign head_job  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && job_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/svpf_back.sv =====
`default_nettype none
module svpf_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  input  wire svpf_pkg::job_t     job,
  output logic                    job_pop,
  output logic                    empty,
  input  wire logic               pop,
  output logic [7:0]              tx_byte,
  output logic                    packet_end,
  output logic                    last_of_item
);
  import svpf_pkg::*;

  logic [3:0] step;
  logic [3:0] pos;
  logic [3:0] last_data;
  logic [7:0] byte_val;
  logic       is_chk;
  logic       final_byte;
  logic       advance;
  logic [7:0] running_sum;
  logic       out_valid;

  // byte position inside the packet
  always_comb begin
    if ((job.op == OP_SYNC_WRITE || job.op == OP_SYNC_READ) && !job.hdr) begin
      pos = step + SYNC_ENTRY_POS;
    end else begin
      pos = step;
    end
  end

  // packet byte selection
  always_comb begin
    byte_val  = 8'h00;
    last_data = 4'd7;
    unique case (job.op)
      OP_TORQUE: begin
        last_data = 4'd7;
        unique case (pos)
          4'd0, 4'd1: byte_val = HDR_BYTE;
          4'd2:       byte_val = job.servo_id;
          4'd3:       byte_val = LEN_TORQUE;
          4'd4:       byte_val = INS_WRITE;
          4'd5:       byte_val = ADDR_TORQUE;
          4'd6:       byte_val = {7'b0, job.enable};
          default:    byte_val = 8'h00;
        endcase
      end
      OP_WRITE_POS: begin
        last_data = 4'd12;
        unique case (pos)
          4'd0, 4'd1: byte_val = HDR_BYTE;
          4'd2:       byte_val = job.servo_id;
          4'd3:       byte_val = LEN_WRITE_POS;
          4'd4:       byte_val = INS_WRITE;
          4'd5:       byte_val = ADDR_GOAL;
          4'd6:       byte_val = job.acceleration;
          4'd7:       byte_val = job.position[7:0];
          4'd8:       byte_val = job.position[15:8];
          4'd9:       byte_val = job.move_time[7:0];
          4'd10:      byte_val = job.move_time[15:8];
          4'd11:      byte_val = job.move_speed[7:0];
          4'd12:      byte_val = job.move_speed[15:8];
          default:    byte_val = 8'h00;
        endcase
      end
      OP_SYNC_WRITE: begin
        last_data = 4'd14;
        unique case (pos)
          4'd0, 4'd1: byte_val = HDR_BYTE;
          4'd2:       byte_val = BCAST_ID;
          4'd3:       byte_val = job.len;
          4'd4:       byte_val = INS_SYNC_WRITE;
          4'd5:       byte_val = ADDR_GOAL;
          4'd6:       byte_val = SW_DATA_LEN;
          4'd7:       byte_val = job.servo_id;
          4'd8:       byte_val = job.acceleration;
          4'd9:       byte_val = job.position[7:0];
          4'd10:      byte_val = job.position[15:8];
          4'd11:      byte_val = job.move_time[7:0];
          4'd12:      byte_val = job.move_time[15:8];
          4'd13:      byte_val = job.move_speed[7:0];
          4'd14:      byte_val = job.move_speed[15:8];
          default:    byte_val = 8'h00;
        endcase
      end
      OP_SYNC_READ: begin
        last_data = 4'd7;
        unique case (pos)
          4'd0, 4'd1: byte_val = HDR_BYTE;
          4'd2:       byte_val = BCAST_ID;
          4'd3:       byte_val = job.len;
          4'd4:       byte_val = INS_SYNC_READ;
          4'd5:       byte_val = ADDR_PRESENT;
          4'd6:       byte_val = SR_DATA_LEN;
          4'd7:       byte_val = job.servo_id;
          default:    byte_val = 8'h00;
        endcase
      end
      default: begin
        byte_val  = 8'h00;
        last_data = 4'd7;
      end
    endcase

    is_chk     = job.chk && (pos == last_data + 4'd1);
    final_byte = is_chk || (!job.chk && (pos == last_data));
    if (is_chk) begin
      byte_val = ~running_sum;
    end
  end

  // one byte per cycle into the output register when it is free or drained
  assign advance = job_valid && (!out_valid || pop);
  assign job_pop = advance && final_byte;
  assign empty   = !out_valid;

  // sequencer, checksum accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= 4'd0;
      out_valid   <= 1'b0;
      running_sum <= 8'h00;
    end else begin
      if (advance) begin
        step      <= final_byte ? 4'd0 : (step + 4'd1);
        out_valid <= 1'b1;
        if (pos < 4'd2 || is_chk) begin
          running_sum <= 8'h00;
        end else begin
          running_sum <= running_sum + byte_val;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      tx_byte      <= byte_val;
      packet_end   <= is_chk;
      last_of_item <= final_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/servo_bus_packet_framer.sv =====
`default_nettype none
// channel   direction  handshake            payload
// command   in         push / full          mode servo_id enable acceleration position
//                                           move_time move_speed entry_count
// bytes     out        pop / empty          tx_byte packet_end last_of_item
//
// The back-end sequencer emits one byte per cycle while the byte side keeps up:
// 9 bytes for torque enable, 14 for write position, up to 16 for a sync entry
// that opens and closes a packet; a dropped sync entry emits nothing.
// A two-entry job queue lets the front take commands while bytes drain.
// rst is synchronous and clears the open sync packet and the job queue.
// A held pop stalls only the sequencer; full rises once the queue fills.
module servo_bus_packet_framer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  servo_id,
  input  wire logic        enable,
  input  wire logic [7:0]  acceleration,
  input  wire logic signed [15:0] position,
  input  wire logic [15:0] move_time,
  input  wire logic [15:0] move_speed,
  input  wire logic [4:0]  entry_count,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       tx_byte,
  output logic             packet_end,
  output logic             last_of_item
);
  import svpf_pkg::*;

  logic take;
  logic job_push;
  job_t new_job;
  logic job_valid;
  job_t head_job;
  logic job_pop;

  // a command transfer
  assign take = push && !full;

  svpf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .mode         (mode),
    .servo_id     (servo_id),
    .enable       (enable),
    .acceleration (acceleration),
    .position     (position),
    .move_time    (move_time),
    .move_speed   (move_speed),
    .entry_count  (entry_count),
    .job_push     (job_push),
    .job          (new_job)
  );

  svpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (new_job),
    .full      (full),
    .pop       (job_pop),
    .job_valid (job_valid),
    .head_job  (head_job)
  );

  svpf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (head_job),
    .job_pop      (job_pop),
    .empty        (empty),
    .pop          (pop),
    .tx_byte      (tx_byte),
    .packet_end   (packet_end),
    .last_of_item (last_of_item)
  );

endmodule
`default_nettype wire

// ===== tb/tb_servo_bus_packet_framer.sv =====
`default_nettype none
module tb_servo_bus_packet_framer;
  timeunit 1ns;
  timeprecision 1ps;

  import svpf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_COMMANDS = 240;
  localparam int HOLD_OFF_CYCLES = 300;

  // one command as offered on the input side
  typedef struct packed {
    op_t         op;
    logic [7:0]  servo_id;
    logic        enable;
    logic [7:0]  acceleration;
    logic [15:0] position;
    logic [15:0] move_time;
    logic [15:0] move_speed;
    logic [4:0]  entry_count;
  } command_t;

  // one byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       pkt_end;
    logic       item_last;
  } line_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] mode = '0;
  logic [7:0] servo_id = '0;
  logic enable = 1'b0;
  logic [7:0] acceleration = '0;
  logic signed [15:0] position = '0;
  logic [15:0] move_time = '0;
  logic [15:0] move_speed = '0;
  logic [4:0] entry_count = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] tx_byte;
  logic packet_end;
  logic last_of_item;

  servo_bus_packet_framer uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .servo_id    (servo_id),
    .enable      (enable),
    .acceleration(acceleration),
    .position    (position),
    .move_time   (move_time),
    .move_speed  (move_speed),
    .entry_count (entry_count),
    .empty       (empty),
    .pop         (pop),
    .tx_byte     (tx_byte),
    .packet_end  (packet_end),
    .last_of_item(last_of_item)
  );

  // clock and the single reset
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  command_t   cmd_pending[$];
  line_byte_t line_expect[$];
  command_t   cmd_on_port;

  // framer state kept alongside the block
  logic [7:0] frame_sum = '0;
  logic [4:0] slots_left = '0;
  logic       read_open = 1'b0;

  int err_count = 0;
  int bytes_seen = 0;
  int packets_seen = 0;
  int dropped_entries = 0;
  int full_stall_cycles = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int cycle_count = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;
  logic hold_off = 1'b0;

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // random wait per transfer, with occasional runs of back-to-back transfers
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic command_t rand_command(op_t op, logic [4:0] cnt);
    command_t c;
    c.op = op;
    c.servo_id = 8'($urandom_range(0, 255));
    c.enable = 1'($urandom_range(0, 1));
    c.acceleration = 8'($urandom_range(0, 255));
    c.position = 16'($urandom_range(0, 65535));
    c.move_time = 16'($urandom_range(0, 65535));
    c.move_speed = 16'($urandom_range(0, 65535));
    c.entry_count = cnt;
    return c;
  endfunction

  function automatic command_t make_cmd(op_t op, logic [7:0] id, logic en, logic [7:0] acc,
                                        logic [15:0] pos, logic [15:0] tim,
                                        logic [15:0] spd, logic [4:0] cnt);
    command_t c;
    c.op = op;
    c.servo_id = id;
    c.enable = en;
    c.acceleration = acc;
    c.position = pos;
    c.move_time = tim;
    c.move_speed = spd;
    c.entry_count = cnt;
    return c;
  endfunction

  function automatic void emit(logic [7:0] b, bit summed);
    line_expect.push_back('{data: b, pkt_end: 1'b0, item_last: 1'b0});
    if (summed) frame_sum = frame_sum + b;
  endfunction

  function automatic void emit_checksum();
    line_expect.push_back('{data: ~frame_sum, pkt_end: 1'b1, item_last: 1'b0});
    frame_sum = '0;
  endfunction

  function automatic void emit16(logic [15:0] v);
    emit(v[7:0], 1'b1);
    emit(v[15:8], 1'b1);
  endfunction

  // bytes that one accepted command puts on the line
  function automatic void frame_command(command_t c);
    int start_size;
    int limit;
    logic is_read;
    logic [7:0] cnt8;
    start_size = line_expect.size();
    cnt8 = {3'd0, c.entry_count};
    if (c.op == OP_TORQUE || c.op == OP_WRITE_POS) begin
      // a whole packet; any open sync packet is abandoned
      slots_left = '0;
      frame_sum = '0;
      emit(HDR_BYTE, 1'b0);
      emit(HDR_BYTE, 1'b0);
      emit(c.servo_id, 1'b1);
      if (c.op == OP_TORQUE) begin
        emit(LEN_TORQUE, 1'b1);
        emit(INS_WRITE, 1'b1);
        emit(ADDR_TORQUE, 1'b1);
        emit({7'd0, c.enable}, 1'b1);
        emit(8'h00, 1'b1);
      end else begin
        emit(LEN_WRITE_POS, 1'b1);
        emit(INS_WRITE, 1'b1);
        emit(ADDR_GOAL, 1'b1);
        emit(c.acceleration, 1'b1);
        emit16(c.position);
        emit16(c.move_time);
        emit16(c.move_speed);
      end
      emit_checksum();
    end else begin
      is_read = (c.op == OP_SYNC_READ);
      // open a new sync packet unless one of the same kind is running
      if (slots_left == 0 || read_open != is_read) begin
        limit = is_read ? MAX_SYNC_READ_ENTRIES : MAX_SYNC_WRITE_ENTRIES;
        slots_left = '0;
        frame_sum = '0;
        if (c.entry_count == 0 || int'(c.entry_count) > limit) begin
          dropped_entries++;
          return;
        end
        emit(HDR_BYTE, 1'b0);
        emit(HDR_BYTE, 1'b0);
        emit(BCAST_ID, 1'b1);
        if (is_read) begin
          emit(cnt8 + SYNC_LEN_BASE, 1'b1);
          emit(INS_SYNC_READ, 1'b1);
          emit(ADDR_PRESENT, 1'b1);
          emit(SR_DATA_LEN, 1'b1);
        end else begin
          emit((cnt8 << 3) + SYNC_LEN_BASE, 1'b1);
          emit(INS_SYNC_WRITE, 1'b1);
          emit(ADDR_GOAL, 1'b1);
          emit(SW_DATA_LEN, 1'b1);
        end
        read_open = is_read;
        slots_left = c.entry_count;
      end
      emit(c.servo_id, 1'b1);
      if (!is_read) begin
        emit(c.acceleration, 1'b1);
        emit16(c.position);
        emit16(c.move_time);
        emit16(c.move_speed);
      end
      slots_left = slots_left - 5'd1;
      if (slots_left == 0) emit_checksum();
    end
    if (line_expect.size() > start_size) line_expect[line_expect.size() - 1].item_last = 1'b1;
  endfunction

  task automatic present_command(command_t c);
    cmd_on_port  <= c;
    mode         <= c.op;
    servo_id     <= c.servo_id;
    enable       <= c.enable;
    acceleration <= c.acceleration;
    position     <= c.position;
    move_time    <= c.move_time;
    move_speed   <= c.move_speed;
    entry_count  <= c.entry_count;
  endtask

  // command side: offer queued commands with random gaps
  always @(posedge clk) begin : cmd_driver
    int w;
    logic push_n;
    if (rst) begin
      push <= 1'b0;
      tx_gap <= 0;
    end else begin
      push_n = push;
      if (push && full) full_stall_cycles++;
      if (push && !full) begin
        frame_command(cmd_on_port);
        op_count[cmd_on_port.op]++;
        w = hold_off ? 0 : draw_wait(tx_calm);
        if (w == 0 && cmd_pending.size() > 0) begin
          present_command(cmd_pending.pop_front());
          push_n = 1'b1;
        end else begin
          push_n = 1'b0;
          tx_gap <= (w > 0) ? w - 1 : 0;
        end
      end else if (!push) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
        end else if (cmd_pending.size() > 0) begin
          present_command(cmd_pending.pop_front());
          push_n = 1'b1;
        end
      end
      push <= push_n;
    end
  end

  // byte side: pop with random stalls and check each transfer
  always @(posedge clk) begin : byte_monitor
    line_byte_t want;
    int w;
    logic pop_n;
    if (rst) begin
      pop <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (pop && !empty) begin
        bytes_seen++;
        if (packet_end) packets_seen++;
        if (line_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h end %0b last %0b",
                                    tx_byte, packet_end, last_of_item));
        end else begin
          want = line_expect.pop_front();
          if (tx_byte !== want.data)
            report_mismatch($sformatf("tx_byte %02h, expected %02h", tx_byte, want.data));
          if (packet_end !== want.pkt_end)
            report_mismatch($sformatf("packet_end %0b, expected %0b on byte %02h",
                                      packet_end, want.pkt_end, want.data));
          if (last_of_item !== want.item_last)
            report_mismatch($sformatf("last_of_item %0b, expected %0b on byte %02h",
                                      last_of_item, want.item_last, want.data));
        end
      end
      if (hold_off) begin
        pop_n = 1'b0;
      end else if (pop && !empty) begin
        w = draw_wait(rx_calm);
        rx_hold <= w;
        pop_n = (w == 0);
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        pop_n = (rx_hold == 1);
      end else begin
        pop_n = 1'b1;
      end
      pop <= pop_n;
    end
  end

  // long receiver hold-off so the job queue fills and full stalls the sender
  initial begin : back_pressure
    do @(negedge clk); while (bytes_seen < 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("servo_bus_packet_framer regression: fail");
    $finish;
  end

  // stimulus, then drain and verdict
  initial begin : stimulus
    int produced;
    int pick;
    int limit;
    int n;
    int sent_n;
    op_t op;

    // torque and write position at the field extremes
    cmd_pending.push_back(make_cmd(OP_TORQUE, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000,
                                   16'h0000, 5'd0));
    cmd_pending.push_back(make_cmd(OP_TORQUE, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 5'd31));
    cmd_pending.push_back(make_cmd(OP_WRITE_POS, 8'hFF, 1'b1, 8'h00, 16'h8000, 16'h0000,
                                   16'hFFFF, 5'd0));
    cmd_pending.push_back(make_cmd(OP_WRITE_POS, 8'h00, 1'b0, 8'hFF, 16'h7FFF, 16'hFFFF,
                                   16'h0000, 5'd31));
    // bad sync counts: zero and one past each limit, nothing comes out
    cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'd0));
    cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'(MAX_SYNC_WRITE_ENTRIES + 1)));
    cmd_pending.push_back(rand_command(OP_SYNC_READ, 5'd0));
    cmd_pending.push_back(rand_command(OP_SYNC_READ, 5'(MAX_SYNC_READ_ENTRIES + 1)));
    // single-entry sync write opens and closes in one item
    cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'd1));
    // largest sync write; continuing entries carry counts that must be ignored
    cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'(MAX_SYNC_WRITE_ENTRIES)));
    cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'd0));
    cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'd31));
    for (int k = 0; k < MAX_SYNC_WRITE_ENTRIES - 3; k++)
      cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'($urandom_range(0, 31))));
    // largest sync read interrupted by a torque command
    cmd_pending.push_back(rand_command(OP_SYNC_READ, 5'(MAX_SYNC_READ_ENTRIES)));
    cmd_pending.push_back(rand_command(OP_SYNC_READ, 5'd0));
    cmd_pending.push_back(rand_command(OP_TORQUE, 5'd0));
    cmd_pending.push_back(rand_command(OP_SYNC_READ, 5'd1));
    // sync write cut short by a sync read, which then completes
    cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'd3));
    cmd_pending.push_back(rand_command(OP_SYNC_READ, 5'd2));
    cmd_pending.push_back(rand_command(OP_SYNC_READ, 5'd9));
    // sync write cut short by a write position
    cmd_pending.push_back(rand_command(OP_SYNC_WRITE, 5'd2));
    cmd_pending.push_back(rand_command(OP_WRITE_POS, 5'd0));

    // random part: mostly whole sync packets, some singles, broken and bad ones
    produced = 0;
    while (produced < RANDOM_COMMANDS) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        op = $urandom_range(0, 1) ? OP_WRITE_POS : OP_TORQUE;
        cmd_pending.push_back(rand_command(op, 5'($urandom_range(0, 31))));
        produced++;
      end else if (pick < 9) begin
        op = $urandom_range(0, 1) ? OP_SYNC_READ : OP_SYNC_WRITE;
        limit = (op == OP_SYNC_READ) ? MAX_SYNC_READ_ENTRIES : MAX_SYNC_WRITE_ENTRIES;
        n = ($urandom_range(0, 7) == 0) ? limit : $urandom_range(1, (limit < 8) ? limit : 8);
        // a broken packet stops early and is left open for the next command
        sent_n = (pick == 8 && n > 1) ? $urandom_range(1, n - 1) : n;
        for (int k = 0; k < sent_n; k++) begin
          cmd_pending.push_back(rand_command(op, (k == 0) ? 5'(n)
                                                          : 5'($urandom_range(0, 31))));
          produced++;
        end
      end else begin
        op = $urandom_range(0, 1) ? OP_SYNC_READ : OP_SYNC_WRITE;
        limit = (op == OP_SYNC_READ) ? MAX_SYNC_READ_ENTRIES : MAX_SYNC_WRITE_ENTRIES;
        cmd_pending.push_back(rand_command(op, $urandom_range(0, 1) ? 5'd0
                                               : 5'($urandom_range(limit + 1, 31))));
      end
    end

    // wait for every command to be taken and every byte to arrive
    do @(negedge clk); while (rst || cmd_pending.size() > 0 || push || line_expect.size() > 0);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (line_expect.size() > 0)
      report_mismatch($sformatf("%0d bytes never arrived", line_expect.size()));

    $display("covered %0d torque, %0d write position, %0d sync write, %0d sync read commands",
             op_count[OP_TORQUE], op_count[OP_WRITE_POS], op_count[OP_SYNC_WRITE],
             op_count[OP_SYNC_READ]);
    $display("checked %0d bytes in %0d packets, %0d entries dropped, %0d cycles stalled on full",
             bytes_seen, packets_seen, dropped_entries, full_stall_cycles);
    if (err_count == 0) begin
      $display("servo_bus_packet_framer regression: pass");
    end else begin
      $display("servo_bus_packet_framer regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
